FILE: src/ssp_pkg.sv
// ssp_pkg: shared widths, register codes, configuration and pipeline-control
// types and saturation helpers for the segment screen projection block.
// No dependencies.
package ssp_pkg;

   // field formats
   localparam int PIXEL_BITS     = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int FIX_FRAC       = 16;
   localparam int COORD_W        = 32;
   localparam int COEF_W         = 16;
   localparam int NUM_COEF       = 3;
   localparam int COL_W          = NUM_COEF * COEF_W;
   localparam int SCALE_W        = 32;
   localparam int ORIGIN_W       = 32;
   localparam int HEIGHT_W       = 15;
   localparam int DEPTH_W        = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // register stages from input transfer to result register
   localparam int NSTAGE = 9;

   // endpoint lane arithmetic
   localparam int PROD_W    = COORD_W + COEF_W;
   localparam int ROT_W     = PROD_W + 1;
   localparam int MAG_W     = PROD_W;
   localparam int SPLIT     = 24;
   localparam int PP_LO_W   = SPLIT + SCALE_W;
   localparam int PP_HI_W   = MAG_W - SPLIT + SCALE_W;
   localparam int FULL_W    = MAG_W + SCALE_W;
   localparam int PIX_SHIFT = COEF_FRAC_BITS + FIX_FRAC;
   localparam int R_W       = FULL_W - PIX_SHIFT;
   localparam int S_W       = R_W + 1;
   localparam int T_W       = ((S_W > ORIGIN_W) ? S_W : ORIGIN_W) + 1;
   localparam int Q_W       = T_W - FIX_FRAC;
   localparam int Y_W       = ((Q_W > PIXEL_BITS) ? Q_W : PIXEL_BITS) + 1;

   // depth merge arithmetic
   localparam int DSUM_W      = ROT_W + 1;
   localparam int DMAG_W      = ROT_W;
   localparam int DPP_LO_W    = SPLIT + SCALE_W;
   localparam int DPP_HI_W    = DMAG_W - SPLIT + SCALE_W;
   localparam int DFULL_W     = DMAG_W + SCALE_W;
   localparam int DEPTH_SHIFT = PIX_SHIFT + 1;
   localparam int DR_W        = DFULL_W - DEPTH_SHIFT;
   localparam int DS_W        = DR_W + 1;

   localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
   localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};
   localparam logic signed [DEPTH_W-1:0]    DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
   localparam logic signed [DEPTH_W-1:0]    DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COLUMN_X      = 3'd0,
      REG_COLUMN_Y      = 3'd1,
      REG_COLUMN_DEPTH  = 3'd2,
      REG_PIXEL_SCALE   = 3'd3,
      REG_ORIGIN_X      = 3'd4,
      REG_ORIGIN_Y      = 3'd5,
      REG_SCREEN_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COL_W-1:0]           col_x;
      logic [COL_W-1:0]           col_y;
      logic [COL_W-1:0]           col_depth;
      logic [SCALE_W-1:0]         scale;
      logic signed [ORIGIN_W-1:0] origin_x;
      logic signed [ORIGIN_W-1:0] origin_y;
      logic [HEIGHT_W-1:0]        height;
   } cfg_type;

   // identity rotation, unit scale
   localparam cfg_type CFG_RESET = '{
      col_x:     48'h0000_0000_4000,
      col_y:     48'h0000_4000_0000,
      col_depth: 48'h4000_0000_0000,
      scale:     32'h0001_0000,
      origin_x:  '0,
      origin_y:  '0,
      height:    '0
   };

   // per-stage advance enables, shared by lanes and merge
   typedef struct packed {
      logic [NSTAGE-1:0] en;
   } pipe_ctl_type;

   function automatic logic signed [COEF_W-1:0] coef_at(
      input logic [COL_W-1:0] column,
      input int               slot
   );
      coef_at = column[slot*COEF_W +: COEF_W];
   endfunction

   function automatic logic signed [PIXEL_BITS-1:0] sat_pixel(
      input logic signed [Y_W-1:0] v
   );
      if (v > Y_W'(PIX_MAX)) begin
         sat_pixel = PIX_MAX;
      end else if (v < Y_W'(PIX_MIN)) begin
         sat_pixel = PIX_MIN;
      end else begin
         sat_pixel = PIXEL_BITS'(v);
      end
   endfunction

   function automatic logic signed [DEPTH_W-1:0] sat_depth(
      input logic signed [DS_W-1:0] v
   );
      if (v > DS_W'(DEPTH_MAX)) begin
         sat_depth = DEPTH_MAX;
      end else if (v < DS_W'(DEPTH_MIN)) begin
         sat_depth = DEPTH_MIN;
      end else begin
         sat_depth = DEPTH_W'(v);
      end
   endfunction

endpackage

FILE: src/segment_screen_projection.sv
// segment_screen_projection: top level; configuration registers, pipeline
// valid/stall control, two endpoint lanes and the depth merge.
// Depends on ssp_pkg, ssp_lane, ssp_merge.

// Projects one 3D segment per clock to two screen pixels and a depth key.
// A segment transferred on req reaches rsp through the nine register stages
// of each endpoint lane (rotation multiply, sum, magnitude, split scale
// multiply, recombine, sign, origin add, truncate, flip and saturate), with
// the depth merge running alongside; the block takes one segment every
// cycle while rsp is not stalled. Every stage holds an item independently,
// so empty stages keep filling during an rsp stall; req_stall rises only
// once the whole pipeline is full and stalled.
// Configuration writes are meant for idle periods and take effect once registered.
module segment_screen_projection
   import ssp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_W-1:0]    req_start_x,
   input  logic signed [COORD_W-1:0]    req_start_y,
   input  logic signed [COORD_W-1:0]    req_start_z,
   input  logic signed [COORD_W-1:0]    req_end_x,
   input  logic signed [COORD_W-1:0]    req_end_y,
   input  logic signed [COORD_W-1:0]    req_end_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [PIXEL_BITS-1:0] rsp_pixel_x_start,
   output logic signed [PIXEL_BITS-1:0] rsp_pixel_y_start,
   output logic signed [PIXEL_BITS-1:0] rsp_pixel_x_end,
   output logic signed [PIXEL_BITS-1:0] rsp_pixel_y_end,
   output logic signed [DEPTH_W-1:0]    rsp_mid_depth
);

   cfg_type           cfg_in, cfg_ff;
   logic [NSTAGE-1:0] valid_in, valid_ff;
   pipe_ctl_type      ctl;
   logic signed [ROT_W-1:0] depth_a, depth_b;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_COLUMN_X:      cfg_in.col_x     = csr_data[COL_W-1:0];
            REG_COLUMN_Y:      cfg_in.col_y     = csr_data[COL_W-1:0];
            REG_COLUMN_DEPTH:  cfg_in.col_depth = csr_data[COL_W-1:0];
            REG_PIXEL_SCALE:   cfg_in.scale     = csr_data[SCALE_W-1:0];
            REG_ORIGIN_X:      cfg_in.origin_x  = csr_data[ORIGIN_W-1:0];
            REG_ORIGIN_Y:      cfg_in.origin_y  = csr_data[ORIGIN_W-1:0];
            REG_SCREEN_HEIGHT: cfg_in.height    = csr_data[HEIGHT_W-1:0];
            default:           cfg_in           = cfg_ff;
         endcase
      end
   end

   // a stage advances when it is empty or its successor advances
   always_comb begin
      ctl.en[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         ctl.en[k] = !valid_ff[k] || ctl.en[k+1];
      end
      valid_in[0] = ctl.en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = ctl.en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         valid_ff <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ctl.en[0];
   assign rsp_valid = valid_ff[NSTAGE-1];

   ssp_lane u_lane_start (
      .clock   (clock),
      .ctl     (ctl),
      .cfg     (cfg_ff),
      .coord_x (req_start_x),
      .coord_y (req_start_y),
      .coord_z (req_start_z),
      .pixel_x (rsp_pixel_x_start),
      .pixel_y (rsp_pixel_y_start),
      .depth   (depth_a)
   );

   ssp_lane u_lane_end (
      .clock   (clock),
      .ctl     (ctl),
      .cfg     (cfg_ff),
      .coord_x (req_end_x),
      .coord_y (req_end_y),
      .coord_z (req_end_z),
      .pixel_x (rsp_pixel_x_end),
      .pixel_y (rsp_pixel_y_end),
      .depth   (depth_b)
   );

   ssp_merge u_merge (
      .clock     (clock),
      .ctl       (ctl),
      .scale     (cfg_ff.scale),
      .depth_a   (depth_a),
      .depth_b   (depth_b),
      .mid_depth (rsp_mid_depth)
   );

endmodule

FILE: src/ssp_lane.sv
// ssp_lane: projects one segment endpoint: rotation by the three columns,
// split-product scaling, origin add, truncation, y flip and saturation.
// Depends on ssp_pkg.
module ssp_lane
   import ssp_pkg::*;
(
   input  logic                         clock,
   input  pipe_ctl_type                 ctl,
   input  cfg_type                      cfg,
   input  logic signed [COORD_W-1:0]    coord_x,
   input  logic signed [COORD_W-1:0]    coord_y,
   input  logic signed [COORD_W-1:0]    coord_z,
   output logic signed [PIXEL_BITS-1:0] pixel_x,
   output logic signed [PIXEL_BITS-1:0] pixel_y,
   output logic signed [ROT_W-1:0]      depth
);

   logic signed [COORD_W-1:0] coord [NUM_COEF];
   logic [COL_W-1:0]          cols  [3];
   logic signed [ORIGIN_W-1:0] origin [2];

   logic signed [PROD_W-1:0] prod_in [3][NUM_COEF];
   logic signed [PROD_W-1:0] prod_ff [3][NUM_COEF];
   logic signed [ROT_W-1:0]  rot_in  [3];
   logic signed [ROT_W-1:0]  rot_ff  [3];

   // stages below carry screen x (0) and screen y (1)
   logic [MAG_W-1:0]         mag_in    [2];
   logic [MAG_W-1:0]         mag_ff    [2];
   logic                     neg2_in   [2];
   logic                     neg2_ff   [2];
   logic [PP_LO_W-1:0]       pp_lo_in  [2];
   logic [PP_LO_W-1:0]       pp_lo_ff  [2];
   logic [PP_HI_W-1:0]       pp_hi_in  [2];
   logic [PP_HI_W-1:0]       pp_hi_ff  [2];
   logic                     neg3_ff   [2];
   logic [FULL_W-1:0]        full      [2];
   logic [R_W-1:0]           r_in      [2];
   logic [R_W-1:0]           r_ff      [2];
   logic                     neg4_ff   [2];
   logic signed [S_W-1:0]    s_in      [2];
   logic signed [S_W-1:0]    s_ff      [2];
   logic signed [T_W-1:0]    t_in      [2];
   logic signed [T_W-1:0]    t_ff      [2];
   logic signed [Q_W-1:0]    q_in      [2];
   logic signed [Q_W-1:0]    q_ff      [2];
   logic signed [Y_W-1:0]    flip_y;
   logic signed [PIXEL_BITS-1:0] px_in, px_ff;
   logic signed [PIXEL_BITS-1:0] py_in, py_ff;

   assign coord[0]  = coord_x;
   assign coord[1]  = coord_y;
   assign coord[2]  = coord_z;
   assign cols[0]   = cfg.col_x;
   assign cols[1]   = cfg.col_y;
   assign cols[2]   = cfg.col_depth;
   assign origin[0] = cfg.origin_x;
   assign origin[1] = cfg.origin_y;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < NUM_COEF; j++) begin
            prod_in[a][j] = PROD_W'(coord[j]) * PROD_W'(coef_at(cols[a], j));
         end
         rot_in[a] = ROT_W'(prod_ff[a][0]) + ROT_W'(prod_ff[a][1]) + ROT_W'(prod_ff[a][2]);
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         neg2_in[a]  = rot_ff[a][ROT_W-1];
         mag_in[a]   = neg2_in[a] ? MAG_W'(-rot_ff[a]) : MAG_W'(rot_ff[a]);
         // magnitude times scale as two partial products of its 24-bit halves
         pp_lo_in[a] = PP_LO_W'(mag_ff[a][SPLIT-1:0]) * PP_LO_W'(cfg.scale);
         pp_hi_in[a] = PP_HI_W'(mag_ff[a][MAG_W-1:SPLIT]) * PP_HI_W'(cfg.scale);
         full[a]     = (FULL_W'(pp_hi_ff[a]) << SPLIT) + FULL_W'(pp_lo_ff[a]);
         r_in[a]     = full[a][FULL_W-1:PIX_SHIFT];
         s_in[a]     = neg4_ff[a] ? $signed(-S_W'(r_ff[a])) : $signed(S_W'(r_ff[a]));
         t_in[a]     = T_W'(s_ff[a]) + T_W'(origin[a]);
         // floor by shift, then bump negatives with a fraction toward zero
         q_in[a]     = t_ff[a][T_W-1:FIX_FRAC]
                     + Q_W'(t_ff[a][T_W-1] && (t_ff[a][FIX_FRAC-1:0] != '0));
      end
   end

   always_comb begin
      flip_y = Y_W'(cfg.height) - Y_W'(q_ff[1]);
      px_in  = sat_pixel(Y_W'(q_ff[0]));
      py_in  = sat_pixel(flip_y);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         prod_ff <= prod_in;
      end
      if (ctl.en[1]) begin
         rot_ff <= rot_in;
      end
      if (ctl.en[2]) begin
         mag_ff  <= mag_in;
         neg2_ff <= neg2_in;
      end
      if (ctl.en[3]) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         neg3_ff  <= neg2_ff;
      end
      if (ctl.en[4]) begin
         r_ff    <= r_in;
         neg4_ff <= neg3_ff;
      end
      if (ctl.en[5]) begin
         s_ff <= s_in;
      end
      if (ctl.en[6]) begin
         t_ff <= t_in;
      end
      if (ctl.en[7]) begin
         q_ff <= q_in;
      end
      if (ctl.en[8]) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign pixel_x = px_ff;
   assign pixel_y = py_ff;
   assign depth   = rot_ff[2];

endmodule

FILE: src/ssp_merge.sv
// ssp_merge: combines the two lanes' depths into the scaled mean depth,
// with split-product scaling, truncation toward zero and saturation.
// Depends on ssp_pkg.
module ssp_merge
   import ssp_pkg::*;
(
   input  logic                      clock,
   input  pipe_ctl_type              ctl,
   input  logic [SCALE_W-1:0]        scale,
   input  logic signed [ROT_W-1:0]   depth_a,
   input  logic signed [ROT_W-1:0]   depth_b,
   output logic signed [DEPTH_W-1:0] mid_depth
);

   logic signed [DSUM_W-1:0]  sum_in, sum_ff;
   logic                      neg_in, neg_ff, neg4_ff, neg5_ff;
   logic [DMAG_W-1:0]         mag_in, mag_ff;
   logic [DPP_LO_W-1:0]       pp_lo_in, pp_lo_ff;
   logic [DPP_HI_W-1:0]       pp_hi_in, pp_hi_ff;
   logic [DFULL_W-1:0]        full;
   logic [DR_W-1:0]           r_in, r_ff;
   logic signed [DS_W-1:0]    s_in, s_ff;
   logic signed [DEPTH_W-1:0] sat_in, sat_ff;
   logic signed [DEPTH_W-1:0] mid_ff;

   always_comb begin
      sum_in   = DSUM_W'(depth_a) + DSUM_W'(depth_b);
      neg_in   = sum_ff[DSUM_W-1];
      mag_in   = neg_in ? DMAG_W'(-sum_ff) : DMAG_W'(sum_ff);
      pp_lo_in = DPP_LO_W'(mag_ff[SPLIT-1:0]) * DPP_LO_W'(scale);
      pp_hi_in = DPP_HI_W'(mag_ff[DMAG_W-1:SPLIT]) * DPP_HI_W'(scale);
      // the extra shift bit halves the sum
      full     = (DFULL_W'(pp_hi_ff) << SPLIT) + DFULL_W'(pp_lo_ff);
      r_in     = full[DFULL_W-1:DEPTH_SHIFT];
      s_in     = neg5_ff ? $signed(-DS_W'(r_ff)) : $signed(DS_W'(r_ff));
      sat_in   = sat_depth(s_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         sum_ff <= sum_in;
      end
      if (ctl.en[3]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
      if (ctl.en[4]) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         neg4_ff  <= neg_ff;
      end
      if (ctl.en[5]) begin
         r_ff    <= r_in;
         neg5_ff <= neg4_ff;
      end
      if (ctl.en[6]) begin
         s_ff <= s_in;
      end
      if (ctl.en[7]) begin
         sat_ff <= sat_in;
      end
      if (ctl.en[8]) begin
         mid_ff <= sat_ff;
      end
   end

   assign mid_depth = mid_ff;

endmodule

FILE: src/ssp_checker.sv
// ssp_checker: port-level assertions for segment_screen_projection and the
// bind that attaches them to the top level.
// Depends on ssp_pkg and segment_screen_projection.
module ssp_checker
   import ssp_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [PIXEL_BITS-1:0] rsp_pixel_x_start,
   input logic signed [PIXEL_BITS-1:0] rsp_pixel_y_start,
   input logic signed [PIXEL_BITS-1:0] rsp_pixel_x_end,
   input logic signed [PIXEL_BITS-1:0] rsp_pixel_y_end,
   input logic signed [DEPTH_W-1:0]    rsp_mid_depth
);

   localparam int RUN_W = $clog2(NSTAGE + 1);
   localparam logic [RUN_W-1:0] RUN_MAX  = '1;
   localparam logic [RUN_W-1:0] RUN_NEED = RUN_W'(NSTAGE - 1);

   logic [NSTAGE-1:0] acc_in, acc_ff;
   logic [RUN_W-1:0]  run_in, run_ff;

   // history of req transfers and length of the current stall-free run
   always_comb begin
      acc_in = {acc_ff[NSTAGE-2:0], req_valid && !req_stall};
      if (rsp_stall) begin
         run_in = '0;
      end else if (run_ff == RUN_MAX) begin
         run_in = run_ff;
      end else begin
         run_in = run_ff + RUN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         run_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         run_ff <= run_in;
      end
   end

   a_stall_from_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall raised without a stalled result");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      acc_ff[NSTAGE-1] && (run_ff >= RUN_NEED) |-> rsp_valid)
      else $error("transfer did not reach rsp in pipeline latency");

   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
         && $stable(rsp_pixel_x_start) && $stable(rsp_pixel_y_start)
         && $stable(rsp_pixel_x_end) && $stable(rsp_pixel_y_end)
         && $stable(rsp_mid_depth))
      else $error("stalled result changed or dropped");

endmodule

bind segment_screen_projection ssp_checker u_ssp_checker (.*);
